// ===== sv/jfhs_pkg.sv =====
// Shared types and constants for the JPEG frame header scanner.
package jfhs_pkg;

  localparam logic [31:0] MaxPixelsReset = 32'd16777216;
  localparam logic [15:0] ScanLimitReset = 16'd8192;

  localparam logic [7:0] ByteFill = 8'hFF;
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] MarkSoi  = 8'hD8;
  localparam logic [7:0] MarkEoi  = 8'hD9;
  localparam logic [7:0] MarkTem  = 8'h01;
  localparam logic [7:0] MarkRst0 = 8'hD0;
  localparam logic [7:0] MarkSofLo = 8'hC0;
  localparam logic [7:0] MarkSofHi = 8'hCF;
  localparam logic [7:0] MarkDht  = 8'hC4;
  localparam logic [7:0] MarkJpg  = 8'hC8;
  localparam logic [7:0] MarkDac  = 8'hCC;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_START = 2'd1,
    CMD_EOF   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_MAX_PIXELS = 1'b0,
    REG_SCAN_LIMIT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_NO_SOI = 2'd1,
    ST_BAD    = 2'd2,
    ST_NO_SOF = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_SOI0     = 4'd1,
    PH_SOI1     = 4'd2,
    PH_HUNT     = 4'd3,
    PH_MARK     = 4'd4,
    PH_LEN0     = 4'd5,
    PH_LEN0_SOF = 4'd6,
    PH_LEN1     = 4'd7,
    PH_LEN1_SOF = 4'd8,
    PH_SKIP     = 4'd9,
    PH_SOF      = 4'd10
  } phase_e;

  typedef struct packed {
    logic        emit;
    status_e     status;
    logic [15:0] width;
    logic [15:0] height;
  } result_t;

endpackage

// ===== sv/jfhs_parser.sv =====
// Marker parser: per-byte scan state and result decision.
module jfhs_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  jfhs_pkg::cmd_e        cmd_i,
  input  logic [7:0]            byte_i,
  input  logic [31:0]           max_pixels_i,
  input  logic [15:0]           scan_limit_i,
  output jfhs_pkg::result_t     result_o
);
  import jfhs_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] iter_q, iter_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [2:0]  hbi_q, hbi_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  width_hi_q, width_hi_d;

  logic [15:0] iter_inc;
  logic [15:0] len_full;
  logic [15:0] skip_dec;
  logic [15:0] width_full;
  logic [31:0] area;
  logic        is_sof;

  assign iter_inc   = iter_q + 16'd1;
  assign len_full   = {len_hi_q, byte_i};
  assign skip_dec   = skip_q - 16'd1;
  assign width_full = {width_hi_q, byte_i};
  assign area       = 32'(width_full) * 32'(height_q);
  assign is_sof     = (byte_i >= MarkSofLo) && (byte_i <= MarkSofHi) &&
                      (byte_i != MarkDht) && (byte_i != MarkJpg) && (byte_i != MarkDac);

  always_comb begin
    phase_d    = phase_q;
    iter_d     = iter_q;
    skip_d     = skip_q;
    len_hi_d   = len_hi_q;
    hbi_d      = hbi_q;
    height_d   = height_q;
    width_hi_d = width_hi_q;
    result_o   = '{emit: 1'b0, status: ST_FOUND, width: 16'd0, height: 16'd0};

    case (cmd_i)
      CMD_START: begin
        phase_d    = PH_SOI0;
        iter_d     = '0;
        skip_d     = '0;
        len_hi_d   = '0;
        hbi_d      = '0;
        height_d   = '0;
        width_hi_d = '0;
      end
      CMD_EOF: begin
        if (phase_q != PH_IDLE) begin
          result_o.emit   = 1'b1;
          result_o.status = (phase_q == PH_SOI0 || phase_q == PH_SOI1) ? ST_NO_SOI
                                                                         : ST_NO_SOF;
          phase_d = PH_IDLE;
        end
      end
      CMD_DATA: begin
        // end_iter marks an outer iteration done: bump the count, then guard
        logic end_iter;
        logic guard;
        logic [15:0] guard_cnt;
        end_iter  = 1'b0;
        guard     = 1'b0;
        guard_cnt = iter_q;
        case (phase_q)
          PH_SOI0: begin
            if (byte_i != ByteFill) begin
              result_o.emit = 1'b1; result_o.status = ST_NO_SOI; phase_d = PH_IDLE;
            end else begin
              phase_d = PH_SOI1;
            end
          end
          PH_SOI1: begin
            if (byte_i != MarkSoi) begin
              result_o.emit = 1'b1; result_o.status = ST_NO_SOI; phase_d = PH_IDLE;
            end else begin
              guard = 1'b1;
            end
          end
          PH_HUNT: begin
            if (byte_i != ByteFill) end_iter = 1'b1;
            else phase_d = PH_MARK;
          end
          PH_MARK: begin
            if (byte_i == ByteFill) begin
              phase_d = PH_MARK;
            end else if (byte_i == ByteZero) begin
              end_iter = 1'b1;
            end else if (byte_i == MarkEoi) begin
              result_o.emit = 1'b1; result_o.status = ST_NO_SOF; phase_d = PH_IDLE;
            end else if (byte_i == MarkTem || (byte_i >= MarkRst0 && byte_i <= MarkSoi)) begin
              end_iter = 1'b1;
            end else begin
              phase_d = is_sof ? PH_LEN0_SOF : PH_LEN0;
            end
          end
          PH_LEN0, PH_LEN0_SOF: begin
            len_hi_d = byte_i;
            phase_d  = (phase_q == PH_LEN0_SOF) ? PH_LEN1_SOF : PH_LEN1;
          end
          PH_LEN1, PH_LEN1_SOF: begin
            if (len_full < 16'd2) begin
              result_o.emit = 1'b1; result_o.status = ST_NO_SOF; phase_d = PH_IDLE;
            end else if (phase_q == PH_LEN1_SOF) begin
              hbi_d   = '0;
              phase_d = PH_SOF;
            end else begin
              skip_d = len_full - 16'd2;
              if (len_full == 16'd2) end_iter = 1'b1;
              else phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 16'd0) end_iter = 1'b1;
          end
          PH_SOF: begin
            hbi_d = hbi_q + 3'd1;
            case (hbi_q)
              3'd0: ;
              3'd1: height_d = {byte_i, 8'h00};
              3'd2: height_d = {height_q[15:8], byte_i};
              3'd3: width_hi_d = byte_i;
              default: begin
                hbi_d         = hbi_q;
                result_o.emit = 1'b1;
                phase_d       = PH_IDLE;
                result_o.width = width_full;
                if (width_full == 16'd0 || height_q == 16'd0 || area > max_pixels_i) begin
                  result_o.status = ST_BAD;
                end else begin
                  result_o.status = ST_FOUND;
                  result_o.height = height_q;
                end
              end
            endcase
          end
          default: ;
        endcase

        if (end_iter) begin
          iter_d    = iter_inc;
          guard     = 1'b1;
          guard_cnt = iter_inc;
        end
        if (guard) begin
          if (guard_cnt >= scan_limit_i) begin
            result_o.emit = 1'b1; result_o.status = ST_NO_SOF; phase_d = PH_IDLE;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      iter_q     <= '0;
      skip_q     <= '0;
      len_hi_q   <= '0;
      hbi_q      <= '0;
      height_q   <= '0;
      width_hi_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      iter_q     <= iter_d;
      skip_q     <= skip_d;
      len_hi_q   <= len_hi_d;
      hbi_q      <= hbi_d;
      height_q   <= height_d;
      width_hi_q <= width_hi_d;
    end
  end

endmodule

// ===== sv/jpeg_frame_header_scanner_unit.sv =====
// JPEG frame header scanner: input register, marker parser, result register.
// A result reaches the master side from the result register, which loads as the
// byte that ends the scan leaves the input register. Throughput: one beat per
// cycle; a stalled result register backs up into the input register.
// Reset: scanner idle awaiting a start command, registers at their defaults,
// both registers empty.
module jpeg_frame_header_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] image_width, [31:16] image_height
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import jfhs_pkg::*;

  logic        in_v_q;
  cmd_e        in_cmd_q;
  logic [7:0]  in_byte_q;
  logic        out_v_q;
  status_e     out_status_q;
  logic [15:0] out_w_q, out_h_q;
  logic [31:0] max_pixels_q;
  logic [15:0] scan_limit_q;
  logic        consume;
  result_t     res;

  assign consume         = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || consume;
  assign cfg_ready_o     = 1'b1;

  jfhs_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (consume),
    .cmd_i        (in_cmd_q),
    .byte_i       (in_byte_q),
    .max_pixels_i (max_pixels_q),
    .scan_limit_i (scan_limit_q),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      max_pixels_q <= MaxPixelsReset;
      scan_limit_q <= ScanLimitReset;
    end else begin
      if (s_axis_tready_o) in_v_q <= s_axis_tvalid_i;
      if (consume && res.emit) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      if (cfg_valid_i && cfg_index_i[7:1] == 7'd0) begin
        case (reg_e'(cfg_index_i[0]))
          REG_MAX_PIXELS: max_pixels_q <= cfg_data_i;
          REG_SCAN_LIMIT: scan_limit_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload holds without reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
    end
    if (consume && res.emit) begin
      out_status_q <= res.status;
      out_w_q      <= res.width;
      out_h_q      <= res.height;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_h_q, out_w_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule
